### rtl/pct_pkg.sv
// Shared types and constants for the pair connection table.
// No dependencies; imported by the table top level.
package pct_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOOKUP      = 2'd0,
    OP_ADD         = 2'd1,
    OP_REMOVE_PAIR = 2'd2,
    OP_REMOVE_ANY  = 2'd3
  } op_e;

  // Outcome of one compare of the shared match unit.
  typedef struct packed {
    logic entry_valid;
    logic pair_hit;
    logic any_hit;
  } match_t;

endpackage

### rtl/pair_connection_table.sv
// Pair connection table: each request scans the entries one per cycle through a
// single RAM read port and one shared id comparator. Lookup and remove-pair stop
// at the first pair hit and add at the first free entry; remove-any scans every
// entry. No new input beat is taken until the scan has ended. One request
// is in flight; a new one is taken while the previous result still waits on the output.
// Reset clears all valid marks at once (flip-flops); id storage has no reset.
module pair_connection_table
  import pct_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] src_id, [15:8] dst_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] found, [1] added, [7:2] removed_count
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
  localparam logic [AW-1:0] IDX_LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]        cmp_idx_q;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_data_q;

  op_e                  op_q;
  logic [ID_W-1:0]      src_q, dst_q;
  logic                 res_found_q, res_found_d;
  logic                 res_added_q, res_added_d;
  logic [COUNT_W-1:0]   res_count_q, res_count_d;

  logic                 in_beat;
  logic                 load_out;
  logic                 rd_en;
  logic                 ram_we;
  logic [2*ID_W-1:0]    rd_data;
  logic [ID_W-1:0]      rd_src, rd_dst;
  match_t               match;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign rd_en    = (state_q == S_SCAN) && (cnt_q < CNT_END);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  pct_ram #(
    .WIDTH (2 * ID_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (cmp_idx_q),
    .wr_data_i ({dst_q, src_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign rd_src = rd_data[ID_W-1:0];
  assign rd_dst = rd_data[2*ID_W-1:ID_W];

  // Shared compare unit, one entry per cycle.
  always_comb begin
    match.entry_valid = valid_q[cmp_idx_q];
    match.pair_hit    = match.entry_valid && (rd_src == src_q) && (rd_dst == dst_q);
    match.any_hit     = match.entry_valid && ((rd_src == src_q) || (rd_dst == dst_q));
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_vld_d   = cmp_vld_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    res_found_d = res_found_q;
    res_added_d = res_added_q;
    res_count_d = res_count_q;
    ram_we      = 1'b0;
    s_axis_tready = (state_q == S_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d     = S_SCAN;
          cnt_d       = '0;
          cmp_vld_d   = 1'b0;
          res_found_d = 1'b0;
          res_added_d = 1'b0;
          res_count_d = '0;
        end
      end
      S_SCAN: begin
        // issue side: one read per cycle
        cmp_vld_d = rd_en;
        if (rd_en) begin
          cnt_d = cnt_q + 1'b1;
        end
        // compare side: data for cmp_idx_q is on the RAM output
        if (cmp_vld_q) begin
          if (cmp_idx_q == IDX_LAST) begin
            state_d = S_DONE;
          end
          case (op_q)
            OP_LOOKUP: begin
              if (match.pair_hit) begin
                res_found_d = 1'b1;
                state_d     = S_DONE;
              end
            end
            OP_ADD: begin
              if (!match.entry_valid) begin
                ram_we              = 1'b1;
                valid_d[cmp_idx_q]  = 1'b1;
                res_added_d         = 1'b1;
                state_d             = S_DONE;
              end
            end
            OP_REMOVE_PAIR: begin
              if (match.pair_hit) begin
                valid_d[cmp_idx_q] = 1'b0;
                res_count_d        = COUNT_W'(1);
                state_d            = S_DONE;
              end
            end
            default: begin
              if (match.any_hit) begin
                valid_d[cmp_idx_q] = 1'b0;
                if (res_count_q != COUNT_MAX) begin
                  res_count_d = res_count_q + 1'b1;
                end
              end
            end
          endcase
        end
        if (state_d == S_DONE) begin
          cmp_vld_d = 1'b0;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= cmp_vld_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q  <= op_e'(s_axis_tuser);
      src_q <= s_axis_tdata[ID_W-1:0];
      dst_q <= s_axis_tdata[2*ID_W-1:ID_W];
    end
    if (rd_en) begin
      cmp_idx_q <= cnt_q[AW-1:0];
    end
    res_found_q <= res_found_d;
    res_added_q <= res_added_d;
    res_count_q <= res_count_d;
    if (load_out) begin
      out_data_q <= {res_count_q, res_added_q, res_found_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_END)
    else $error("scan counter past table end");

  a_add_to_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !valid_q[cmp_idx_q])
    else $error("add overwrote a valid entry");

  a_add_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(cmp_idx_q)])
    else $error("added entry not marked valid");

  a_one_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("found and added both set");

  a_flags_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1])) |-> (m_axis_tdata[7:2] == '0))
    else $error("count set on lookup or add result");
`endif

endmodule

### rtl/pct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
